### src/nte_pkg.sv
package nte_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned LINK_W = 48;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RTT_W  = 16;
  localparam int unsigned EST_W  = 20;
  localparam int unsigned TO_W   = 11;
  localparam int unsigned RTO_W  = 20;
  localparam int unsigned CALC_W = 23;

  // Estimator and table constants.
  localparam logic [EST_W-1:0] INIT_RTTVAR  = 20'd240;
  localparam logic [TO_W-1:0]  INIT_TIMEOUT = 11'd120;
  localparam logic [RTO_W-1:0] RTO_SCALE    = 20'd500;
  localparam logic [TO_W-1:0]  FLOOR_RESET  = 11'd20;
  localparam logic [TO_W-1:0]  CEIL_RESET   = 11'd1280;
  localparam logic signed [CALC_W-1:0] EST_MAX_S = 23'sd1048575;

  // Operation codes carried in the input tuser.
  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_STAMP  = 3'd2,
    FUNC_SAMPLE = 3'd3,
    FUNC_QUERY  = 3'd4,
    FUNC_INC_ID = 3'd5
  } func_e;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_DONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_RTO_FLOOR = 1'b0,
    CFG_RTO_CEIL  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_EXEC,
    ST_EST,
    ST_FINISH
  } state_e;

  // One entry of the data memory, the key lives in its own memory.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] ack_time;
    logic [EST_W-1:0]  srtt;
    logic [EST_W-1:0]  rttvar;
    logic [TO_W-1:0]   timeout;
  } entry_t;

  // Estimator result handed back to the table controller.
  typedef struct packed {
    logic [EST_W-1:0] srtt;
    logic [EST_W-1:0] rttvar;
    logic [TO_W-1:0]  timeout;
  } est_res_t;

  // Keep an estimator value inside [1, 2^20-1].
  function automatic logic [EST_W-1:0] bound_est(input logic signed [CALC_W-1:0] v);
    logic [EST_W-1:0] r;
    if (v <= $signed(23'sd0)) begin
      r = 20'd1;
    end else if (v > EST_MAX_S) begin
      r = EST_MAX_S[EST_W-1:0];
    end else begin
      r = v[EST_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/nte_rto_est.sv
module nte_rto_est (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nte_pkg::EST_W-1:0]  srtt_i,
  input  logic [nte_pkg::EST_W-1:0]  rttvar_i,
  input  logic [nte_pkg::RTT_W-1:0]  rtt_i,
  input  logic [nte_pkg::TO_W-1:0]   floor_i,
  input  logic [nte_pkg::TO_W-1:0]   ceil_i,
  output logic                       done_o,
  output nte_pkg::est_res_t          res_o
);
  import nte_pkg::*;

  logic                     v1_q, v2_q, v3_q;
  logic                     s1_first_q;
  logic [EST_W-1:0]         s1_srtt_q, s1_srtt_d;
  logic [EST_W-1:0]         s1_var_q;
  logic [RTT_W-1:0]         s1_rtt_q;
  logic signed [CALC_W-1:0] s1_abs_q, s1_abs_d;
  logic [EST_W-1:0]         s2_srtt_q;
  logic [EST_W-1:0]         s2_var_q, s2_var_d;
  est_res_t                 res_q, res_d;

  logic                     first;
  logic signed [CALC_W-1:0] delta, sum;
  logic signed [CALC_W-1:0] vsum;
  logic [EST_W:0]           t_sum;

  // Stage one: smoothed RTT update and the magnitude of the error.
  always_comb begin
    first = (srtt_i == '0);
    delta = $signed({7'b0, rtt_i}) - 23'sd1 - $signed({6'b0, srtt_i[EST_W-1:3]});
    sum   = $signed({3'b0, srtt_i}) + delta;
    s1_abs_d  = (delta < $signed(23'sd0)) ? -delta : delta;
    s1_srtt_d = first ? {1'b0, rtt_i, 3'b0} : bound_est(sum);
  end

  // Stage two: variance update.
  always_comb begin
    vsum = $signed({3'b0, s1_var_q}) + s1_abs_q - $signed({5'b0, s1_var_q[EST_W-1:2]});
    s2_var_d = s1_first_q ? {3'b0, s1_rtt_q, 1'b0} : bound_est(vsum);
  end

  // Stage three: timeout from both estimates, clamped, floor tested first.
  always_comb begin
    t_sum = {4'b0, s2_srtt_q[EST_W-1:3]} + {1'b0, s2_var_q};
    res_d.srtt   = s2_srtt_q;
    res_d.rttvar = s2_var_q;
    if (t_sum < {10'b0, floor_i}) begin
      res_d.timeout = floor_i;
    end else if (t_sum > {10'b0, ceil_i}) begin
      res_d.timeout = ceil_i;
    end else begin
      res_d.timeout = t_sum[TO_W-1:0];
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    s1_first_q <= first;
    s1_srtt_q  <= s1_srtt_d;
    s1_var_q   <= rttvar_i;
    s1_rtt_q   <= rtt_i;
    s1_abs_q   <= s1_abs_d;
    s2_srtt_q  <= s1_srtt_q;
    s2_var_q   <= s2_var_d;
    res_q      <= res_d;
  end

  assign done_o = v3_q;
  assign res_o  = res_q;

endmodule

### src/neighbor_table_rtt_estimator_top.sv
// Neighbor table with a per-neighbor retransmit timeout estimator.
// Input beats arrive on the s_axis channel: tuser holds the operation code and
// tdata the neighbor address, hardware address, RTT sample and current time.
// Every input beat yields exactly one output beat on the m_axis channel, with
// the status in tuser and the query fields in tdata (zero unless a query hit).
// The block works on one beat at a time. The key lookup walks the key memory
// one entry per cycle through its single read port. A hit on a stamp or id
// increment then adds a data memory read-modify-write, a hit on a query a
// data memory read, and a hit on an RTT sample runs the three-stage estimator
// between the data memory read and the write-back of the new estimates.
// Reset clears all entry valid bits at once and loads the timeout floor with
// 20 and the ceiling with 1280; no clearing pass is needed.
// The result is held in an output register. While the receiver stalls, the
// block still takes the next beat and works on it, and waits only when that
// next result is ready and the register is still full.
module neighbor_table_rtt_estimator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [nte_pkg::TO_W-1:0]   cfg_data_i,
  // Input stream.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // neighbor_addr[31:0], link_addr[79:32], rtt_sample[95:80], now_stamp[127:96]
  input  logic [127:0]               s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]                 s_axis_tuser_i,
  // Output stream.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tag_out[15:0], ack_request_time[47:16], link_addr_out[95:48],
  // rto_value[115:96], zero fill [119:116]
  output logic [119:0]               m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                 m_axis_tuser_o
);
  import nte_pkg::*;

  state_e             state_q, state_d;

  // Configuration registers.
  logic [TO_W-1:0]    floor_q, ceil_q;

  // Latched input beat.
  logic [2:0]         func_q;
  logic [KEY_W-1:0]   key_q;
  logic [LINK_W-1:0]  link_q;
  logic [RTT_W-1:0]   rtt_q;
  logic [TIME_W-1:0]  now_q;

  // Key memory and lookup scan.
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [KEY_W-1:0]   key_rd_q;
  logic [CNT_W-1:0]   scan_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               cmp_vld_q;
  logic               cmp_live_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [ENTRIES-1:0] valid_q;

  // Data memory.
  entry_t             data_mem [ENTRIES];
  entry_t             rd_q;

  // Pending result and output register.
  status_e            pend_status_q;
  logic [TAG_W-1:0]   pend_tag_q;
  logic [TIME_W-1:0]  pend_ack_q;
  logic [LINK_W-1:0]  pend_link_q;
  logic [RTO_W-1:0]   pend_rto_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [TIME_W-1:0]  out_ack_q;
  logic [LINK_W-1:0]  out_link_q;
  logic [RTO_W-1:0]   out_rto_q;

  // Control strobes.
  logic               in_fire;
  logic               scan_issue, scan_hit, scan_end;
  logic               out_free, out_load;
  logic               op_known;
  logic               add_we, del_we;
  logic               data_we;
  logic [IDX_W-1:0]   data_waddr;
  entry_t             data_wdata;
  logic               fetch_re;
  logic               est_start, est_done;
  est_res_t           est_res;
  logic [TO_W-1:0]    init_timeout;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign op_known = (func_q <= FUNC_INC_ID);

  // Scan bookkeeping: a read is issued while entries remain, the compare
  // follows in the next cycle on the registered key.
  assign scan_issue = (state_q == ST_SCAN) && (scan_q != CNT_W'(ENTRIES));
  assign scan_hit   = (state_q == ST_SCAN) && cmp_vld_q && cmp_live_q && (key_rd_q == key_q);
  assign scan_end   = (state_q == ST_SCAN) && (scan_q == CNT_W'(ENTRIES)) && !scan_hit;

  assign init_timeout = (INIT_TIMEOUT > ceil_q) ? ceil_q : INIT_TIMEOUT;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          if (func_q == FUNC_ADD || func_q == FUNC_DELETE || !op_known) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_FETCH;
          end
        end else if (scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = (func_q == FUNC_SAMPLE) ? ST_EST : ST_FINISH;
      end
      ST_EST: begin
        if (est_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshakes and memory write strobes.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_FINISH) && out_free;
    add_we     = scan_end && (func_q == FUNC_ADD) && free_found_q;
    del_we     = scan_hit && (func_q == FUNC_DELETE);
    fetch_re   = (state_q == ST_FETCH);
    est_start  = (state_q == ST_EXEC) && (func_q == FUNC_SAMPLE);
    data_we    = 1'b0;
    data_waddr = hit_idx_q;
    data_wdata = rd_q;
    if (add_we) begin
      data_we            = 1'b1;
      data_waddr         = free_idx_q;
      data_wdata.link    = link_q;
      data_wdata.tag     = 16'd1;
      data_wdata.ack_time = '0;
      data_wdata.srtt    = '0;
      data_wdata.rttvar  = INIT_RTTVAR;
      data_wdata.timeout = init_timeout;
    end else if (state_q == ST_EXEC && func_q == FUNC_STAMP) begin
      data_we             = 1'b1;
      data_wdata.ack_time = now_q;
    end else if (state_q == ST_EXEC && func_q == FUNC_INC_ID) begin
      data_we        = 1'b1;
      data_wdata.tag = rd_q.tag + 16'd1;
    end else if (state_q == ST_EST && est_done) begin
      data_we            = 1'b1;
      data_wdata.srtt    = est_res.srtt;
      data_wdata.rttvar  = est_res.rttvar;
      data_wdata.timeout = est_res.timeout;
    end
  end

  // State register and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      floor_q <= FLOOR_RESET;
      ceil_q  <= CEIL_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RTO_FLOOR: floor_q <= cfg_data_i;
          CFG_RTO_CEIL:  ceil_q  <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  // Scan control and entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
    end else begin
      if (in_fire) begin
        scan_q       <= '0;
        cmp_vld_q    <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        cmp_vld_q <= scan_issue;
        if (scan_issue) begin
          scan_q <= scan_q + CNT_W'(1);
          if (!valid_q[scan_q[IDX_W-1:0]] && !free_found_q) begin
            free_found_q <= 1'b1;
          end
        end
      end
      if (add_we) valid_q[free_idx_q] <= 1'b1;
      if (del_we) valid_q[cmp_idx_q]  <= 1'b0;
    end
  end

  // Scan payload: index of the compare in flight, first free slot, hit slot.
  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      cmp_idx_q  <= scan_q[IDX_W-1:0];
      cmp_live_q <= valid_q[scan_q[IDX_W-1:0]];
      if (!valid_q[scan_q[IDX_W-1:0]] && !free_found_q) begin
        free_idx_q <= scan_q[IDX_W-1:0];
      end
    end
    if (scan_hit) hit_idx_q <= cmp_idx_q;
  end

  // Key memory: one read port for the scan, written on add.
  always_ff @(posedge clk_i) begin
    if (scan_issue) key_rd_q <= key_mem[scan_q[IDX_W-1:0]];
    if (add_we)     key_mem[free_idx_q] <= key_q;
  end

  // Data memory: read the hit entry, write back the modified entry.
  always_ff @(posedge clk_i) begin
    if (fetch_re) rd_q <= data_mem[hit_idx_q];
    if (data_we)  data_mem[data_waddr] <= data_wdata;
  end

  // Input beat capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[31:0];
      link_q <= s_axis_tdata_i[79:32];
      rtt_q  <= s_axis_tdata_i[95:80];
      now_q  <= s_axis_tdata_i[127:96];
    end
  end

  // Pending result, built up while the item is worked on.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_status_q <= STAT_NONE;
      pend_tag_q    <= '0;
      pend_ack_q    <= '0;
      pend_link_q   <= '0;
      pend_rto_q    <= '0;
    end
    if (scan_hit) begin
      pend_status_q <= (func_q == FUNC_ADD || !op_known) ? STAT_NONE : STAT_DONE;
    end
    if (scan_end && func_q == FUNC_ADD) begin
      pend_status_q <= free_found_q ? STAT_DONE : STAT_FULL;
    end
    if (state_q == ST_EXEC && func_q == FUNC_QUERY) begin
      pend_tag_q  <= rd_q.tag;
      pend_ack_q  <= rd_q.ack_time;
      pend_link_q <= rd_q.link;
      pend_rto_q  <= {9'b0, rd_q.timeout} * RTO_SCALE;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_tag_q    <= pend_tag_q;
      out_ack_q    <= pend_ack_q;
      out_link_q   <= pend_link_q;
      out_rto_q    <= pend_rto_q;
    end
  end

  // Estimator for RTT samples.
  nte_rto_est u_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (est_start),
    .srtt_i   (rd_q.srtt),
    .rttvar_i (rd_q.rttvar),
    .rtt_i    (rtt_q),
    .floor_i  (floor_q),
    .ceil_i   (ceil_q),
    .done_o   (est_done),
    .res_o    (est_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {4'b0, out_rto_q, out_link_q, out_ack_q, out_tag_q};

endmodule
